// ===== rtl/segment_max_point_query_tree_core_assert.svh =====
// assertion macros for the segment max point query tree core
`ifndef SEGMENT_MAX_POINT_QUERY_TREE_CORE_ASSERT_SVH
`define SEGMENT_MAX_POINT_QUERY_TREE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// implication checked every clock, skipped in reset
`define SMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, skipped in reset
`define SMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/smq_pkg.sv =====
// shared types and constants for the segment max point query tree core
package smq_pkg;
    localparam int MAX_LINES  = 131071;
    localparam int TREE_NODES = 131072;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ID_BITS    = 17;
    localparam int NODE_BITS  = 17;
    localparam int Y_BITS     = 30;
    localparam int SLOPE_BITS = 47;
    localparam int HGT_BITS   = 64;
    localparam int STK_DEPTH  = 32;
    localparam int STK_BITS   = 5;
    localparam int STK_ENT    = NODE_BITS + 2 * COORD_BITS;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [HGT_BITS-1:0] t_hgt;

    // one stored line
    typedef struct packed {
        logic signed [SLOPE_BITS-1:0] slope;
        t_coord                       sx;
        logic [Y_BITS-1:0]            sy;
    } t_line;
    localparam int LINE_BITS = SLOPE_BITS + COORD_BITS + Y_BITS;

    // divider handshake
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;
endpackage

// ===== rtl/smq_ram.sv =====
// generic single-port-write, single-read synchronous ram with registered read
module smq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/smq_div.sv =====
// restoring divider, one quotient bit per cycle, truncates toward zero
module smq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smq_pkg::t_div_ctl            i_ctl,
    input  logic [46:0]                  i_num,
    input  logic [15:0]                  i_den,
    output logic                         o_done,
    output logic signed [46:0]           o_quot
);
    import smq_pkg::*;
    logic [46:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [16:0] w_try;
    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_neg = r_neg;
        n_done = 1'b0;
        w_try = {r_rem[15:0], r_q[46]};
        if (i_ctl.start) begin
            n_q = i_num; n_rem = '0; n_cnt = 6'd47; n_busy = 1'b1; n_neg = i_ctl.neg;
        end else if (r_busy) begin
            if (w_try >= {1'b0, i_den}) begin
                n_rem = w_try - {1'b0, i_den};
                n_q   = {r_q[45:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q   = {r_q[45:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_neg <= n_neg;
    end
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== rtl/segment_max_point_query_tree_core.sv =====
// top level: li chao tree over line segments, node and line stores in ram
// a query walks the tree one level at a time and skips the walk when x is outside the tree
// an insert first divides for the slope (skipped if vertical) and writes the line, then steps
// through each node visited plus range checks and stack pops; each node step is set by ram reads
// throughput: one transaction at a time, busy is high until it is finished
// reset clears control at once, then a clearing pass zeroes every node ram entry
module segment_max_point_query_tree_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic                          i_cmd,
    input  logic [15:0]                   i_query_pos,
    input  logic [15:0]                   i_seg_x0,
    input  logic [29:0]                   i_seg_y0,
    input  logic [15:0]                   i_seg_x1,
    input  logic [29:0]                   i_seg_y1,
    output logic                          o_valid,
    output logic [smq_pkg::ID_BITS-1:0]   o_best_line
);
    import smq_pkg::*;
    `include "segment_max_point_query_tree_core_assert.svh"

    // state codes
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_WL   = 4'd3;  // write the new line, start the cover walk
    localparam logic [3:0] S_POP  = 4'd4;  // insert: take range from stack
    localparam logic [3:0] S_CHK  = 4'd5;  // insert: classify the current range
    localparam logic [3:0] S_NRD  = 4'd6;  // node ram read issued
    localparam logic [3:0] S_LRD  = 4'd7;  // line ram read issued
    localparam logic [3:0] S_H1   = 4'd8;  // stored line arrives
    localparam logic [3:0] S_H2   = 4'd9;  // products for l / r
    localparam logic [3:0] S_H3   = 4'd10; // compare at l / r, products for mid
    localparam logic [3:0] S_DEC  = 4'd11; // compare at mid, decide and step down
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]   r_st, n_st;
    logic [15:0]  r_xup;
    logic         r_ins, n_ins;
    t_id          r_next, n_next;
    t_node        r_node, n_node;
    t_coord       r_l, n_l, r_r, n_r, r_lo, n_lo, r_hi, n_hi, r_qx, n_qx;
    t_id          r_id, n_id, r_cur, n_cur, r_best, n_best;
    logic         r_have, n_have;
    t_line        r_new, n_new, r_cl, n_cl, r_seg, n_seg;
    logic         r_valid, n_valid;
    logic [STK_BITS:0] r_sp, n_sp;
    logic [16:0]  r_clr, n_clr;

    // node memory
    logic         w_nwe;
    t_node        w_nwa, w_nra;
    t_id          w_nwd, w_nrd;
    smq_ram #(.WIDTH(ID_BITS), .DEPTH(TREE_NODES)) u_node_ram (
        .i_clk(i_clk), .i_we(w_nwe), .i_waddr(w_nwa), .i_wdata(w_nwd),
        .i_raddr(w_nra), .o_rdata(w_nrd));

    // line memory, indexed by id
    logic         w_lwe;
    t_id          w_lra;
    t_line        w_lrd;
    logic [LINE_BITS-1:0] w_lrd_raw;
    smq_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_LINES + 1)) u_line_ram (
        .i_clk(i_clk), .i_we(w_lwe), .i_waddr(r_id), .i_wdata(r_new),
        .i_raddr(w_lra), .o_rdata(w_lrd_raw));
    assign w_lrd = t_line'(w_lrd_raw);

    // range stack for the covering descent (tree depth bounds it)
    logic         w_spush;
    logic [STK_ENT-1:0] w_sdata, r_stk [STK_DEPTH];
    always_ff @(posedge i_clk) begin
        if (w_spush) r_stk[r_sp[STK_BITS-1:0]] <= w_sdata;
    end
    logic [STK_ENT-1:0] w_stop;
    assign w_stop = r_stk[r_sp[STK_BITS-1:0] - 1'b1];

    // divider for the slope
    t_div_ctl     w_dctl;
    logic         w_ddone;
    logic signed [46:0] w_dq;
    logic [29:0]  w_dy;
    logic [15:0]  w_dx;
    smq_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl),
        .i_num({1'b0, w_dy, 16'd0}), .i_den(w_dx), .o_done(w_ddone), .o_quot(w_dq));

    // ordered endpoints
    logic         w_sw;
    t_coord       w_x0, w_x1;
    logic [29:0]  w_y0, w_y1;
    assign w_sw = i_seg_x1 < i_seg_x0;
    assign w_x0 = w_sw ? i_seg_x1 : i_seg_x0;
    assign w_x1 = w_sw ? i_seg_x0 : i_seg_x1;
    assign w_y0 = w_sw ? i_seg_y1 : i_seg_y0;
    assign w_y1 = w_sw ? i_seg_y0 : i_seg_y1;
    assign w_dy = (w_y1 >= w_y0) ? (w_y1 - w_y0) : (w_y0 - w_y1);
    assign w_dx = w_x1 - w_x0;

    // height products: slope * (p - sx) for each line at points a and b
    t_coord       w_m;
    assign w_m = t_coord'(({1'b0, r_l} + {1'b0, r_r}) >> 1);
    logic signed [17:0] w_dn_a, w_dn_b, w_dc_a, w_dc_b;
    t_coord       w_pa, w_pb;
    logic signed [HGT_BITS-1:0] r_pn_a, r_pn_b, r_pc_a, r_pc_b;
    logic signed [HGT_BITS-1:0] w_hn_a, w_hn_b, w_hc_a, w_hc_b;
    // point a: l (insert) or qx (query); point b: r in S_H2, mid after
    assign w_pa = r_ins ? r_l : r_qx;
    assign w_pb = (r_st == S_H2) ? r_r : w_m;
    assign w_dn_a = $signed({2'b0, w_pa}) - $signed({2'b0, r_new.sx});
    assign w_dn_b = $signed({2'b0, w_pb}) - $signed({2'b0, r_new.sx});
    assign w_dc_a = $signed({2'b0, w_pa}) - $signed({2'b0, r_cl.sx});
    assign w_dc_b = $signed({2'b0, w_pb}) - $signed({2'b0, r_cl.sx});
    assign w_hn_a = r_pn_a + $signed({18'd0, r_new.sy, 16'd0});
    assign w_hn_b = r_pn_b + $signed({18'd0, r_new.sy, 16'd0});
    assign w_hc_a = r_pc_a + $signed({18'd0, r_cl.sy, 16'd0});
    assign w_hc_b = r_pc_b + $signed({18'd0, r_cl.sy, 16'd0});

    // loses(a,b): a below b, or equal with larger id; id 0 has height 0
    function automatic logic f_loses(input t_hgt ha, input t_id a,
                                     input t_hgt hb, input t_id b);
        t_hgt va, vb;
        begin
            va = (a == '0) ? '0 : ha;
            vb = (b == '0) ? '0 : hb;
            f_loses = (va != vb) ? (va < vb) : (a > b);
        end
    endfunction

    // compare flags registered after sums (one compare per cycle each)
    logic r_nl_l, r_nl_r, r_cl_l, r_cl_r, n_nl_l, n_nl_r, n_cl_l, n_cl_r;
    logic w_cm;

    always_ff @(posedge i_clk) begin
        r_pn_a <= HGT_BITS'(r_new.slope * w_dn_a);
        r_pc_a <= HGT_BITS'(r_cl.slope * w_dc_a);
        r_pn_b <= HGT_BITS'(r_new.slope * w_dn_b);
        r_pc_b <= HGT_BITS'(r_cl.slope * w_dc_b);
    end

    t_node w_lc, w_rc;
    assign w_lc = t_node'({r_node, 1'b0});
    assign w_rc = t_node'({r_node, 1'b1});
    // children exist only below the top half of the node range
    logic w_lc_ok;
    assign w_lc_ok = r_node[NODE_BITS-1] == 1'b0;

    always_comb begin
        n_st = r_st; n_ins = r_ins; n_next = r_next; n_node = r_node;
        n_l = r_l; n_r = r_r; n_lo = r_lo; n_hi = r_hi; n_qx = r_qx;
        n_id = r_id; n_cur = r_cur; n_best = r_best; n_have = r_have;
        n_new = r_new; n_cl = r_cl; n_seg = r_seg; n_valid = 1'b0; n_sp = r_sp;
        n_clr = r_clr;
        n_nl_l = r_nl_l; n_nl_r = r_nl_r; n_cl_l = r_cl_l; n_cl_r = r_cl_r;
        w_nwe = 1'b0; w_nwa = r_node; w_nwd = r_id; w_nra = r_node;
        w_lwe = 1'b0; w_lra = r_cur;
        w_spush = 1'b0; w_sdata = '0;
        w_dctl = '0;
        w_cm = 1'b0;
        case (r_st)
            S_CLR: begin
                w_nwe = 1'b1; w_nwa = r_clr; w_nwd = '0;
                n_clr = r_clr + 17'd1;
                if (r_clr == 17'h1FFFF) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_ins = i_cmd; n_qx = i_query_pos;
                    n_node = t_node'(1); n_l = 16'd1; n_r = r_xup;
                    n_id = '0; n_have = 1'b0;
                    if (i_cmd == CMD_QUERY) begin
                        if (i_query_pos == '0 || i_query_pos > r_xup) begin
                            n_st = S_OUT;
                        end else begin
                            n_st = S_NRD;
                        end
                    end else if (r_next >= t_id'(MAX_LINES)) begin
                        // ids used up, insert dropped
                        n_st = S_IDLE;
                    end else begin
                        n_next = r_next + 1'b1; n_id = r_next + 1'b1;
                        n_lo = w_x0; n_hi = w_x1;
                        n_new.sx = w_x0;
                        if (w_x0 == w_x1) begin
                            // vertical: flat at the taller end
                            n_new.slope = '0;
                            n_new.sy = (w_y0 > w_y1) ? w_y0 : w_y1;
                            n_st = S_WL;
                        end else begin
                            n_new.sy = w_y0;
                            w_dctl.start = 1'b1; w_dctl.neg = w_y1 < w_y0;
                            n_st = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_ddone) begin
                    n_new.slope = w_dq;
                    n_st = S_WL;
                end
            end
            S_WL: begin
                w_lwe = 1'b1;
                n_seg = r_new;
                n_sp = '0;
                if (r_xup == '0) n_st = S_IDLE;
                else begin
                    n_node = t_node'(1); n_l = 16'd1; n_r = r_xup;
                    n_st = S_CHK;
                end
            end
            S_POP: begin
                if (r_sp == '0) n_st = S_IDLE;
                else begin
                    n_sp = r_sp - 1'b1;
                    {n_node, n_l, n_r} = w_stop;
                    n_st = S_CHK;
                end
            end
            S_CHK: begin
                if (r_r < r_lo || r_hi < r_l || r_l > r_r) begin
                    n_st = S_POP;
                end else if (r_lo <= r_l && r_r <= r_hi) begin
                    // fully covered: push the new line down from here
                    n_id = r_next; n_new = r_seg; n_st = S_NRD;
                end else if (w_lc_ok) begin
                    // split: park the right half, go on with the left
                    w_spush = 1'b1;
                    w_sdata = {w_rc, w_m + 16'd1, r_r};
                    n_sp = r_sp + 1'b1;
                    n_node = w_lc; n_r = w_m;
                    n_st = S_CHK;
                end else begin
                    n_st = S_POP;
                end
            end
            S_NRD: begin
                w_nra = r_node; n_st = S_LRD;
            end
            S_LRD: begin
                n_cur = w_nrd; w_lra = w_nrd; n_st = S_H1;
            end
            S_H1: begin
                n_cl = w_lrd; n_st = S_H2;
            end
            S_H2: begin
                // products for l/qx and r valid next cycle
                n_st = S_H3;
            end
            S_H3: begin
                n_nl_l = f_loses(w_hn_a, r_id, w_hc_a, r_cur);
                n_nl_r = f_loses(w_hn_b, r_id, w_hc_b, r_cur);
                n_cl_l = f_loses(w_hc_a, r_cur, w_hn_a, r_id);
                n_cl_r = f_loses(w_hc_b, r_cur, w_hn_b, r_id);
                n_st = S_DEC;
            end
            S_DEC: begin
                if (!r_ins) begin
                    // query: r_id / r_new hold the best line so far
                    if (!r_have || r_nl_l) begin
                        n_id = r_cur; n_new = r_cl;
                    end
                    n_have = 1'b1;
                    if (r_l >= r_r) n_st = S_OUT;
                    else if (r_qx <= w_m) begin
                        n_node = w_lc; n_r = w_m;
                        n_st = w_lc_ok ? S_NRD : S_OUT;
                    end else begin
                        n_node = w_rc; n_l = w_m + 16'd1;
                        n_st = w_lc_ok ? S_NRD : S_OUT;
                    end
                end else if (r_nl_l && r_nl_r) n_st = S_POP;
                else if (r_cl_l && r_cl_r) begin
                    w_nwe = 1'b1; n_st = S_POP;
                end else if (r_l >= r_r) n_st = S_POP;
                else begin
                    // winner at mid keeps the node, the other goes down
                    w_cm = f_loses(w_hc_b, r_cur, w_hn_b, r_id);
                    if (w_cm) begin
                        w_nwe = 1'b1; n_id = r_cur; n_new = r_cl;
                    end
                    if (w_cm ? r_nl_l : r_cl_l) begin
                        n_node = w_lc; n_r = w_m;
                    end else begin
                        n_node = w_rc; n_l = w_m + 16'd1;
                    end
                    n_st = w_lc_ok ? S_NRD : S_POP;
                end
            end
            S_OUT: begin
                n_valid = 1'b1; n_best = r_id; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_next <= '0; r_sp <= '0;
            r_valid <= 1'b0; r_xup <= 16'd40000;
        end else begin
            r_st <= n_st; r_clr <= n_clr; r_next <= n_next; r_sp <= n_sp;
            r_valid <= n_valid;
            if (i_cfg_we) r_xup <= i_cfg_wdata;
        end
        r_ins <= n_ins; r_node <= n_node; r_l <= n_l; r_r <= n_r;
        r_lo <= n_lo; r_hi <= n_hi; r_qx <= n_qx; r_id <= n_id; r_cur <= n_cur;
        r_best <= n_best; r_have <= n_have; r_new <= n_new; r_cl <= n_cl;
        r_seg <= n_seg;
        r_nl_l <= n_nl_l; r_nl_r <= n_nl_r; r_cl_l <= n_cl_l; r_cl_r <= n_cl_r;
    end

    assign busy        = (r_st != S_IDLE);
    assign o_valid     = r_valid;
    assign o_best_line = r_best;

    `SMQ_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy && i_cmd == CMD_QUERY, busy)
    `SMQ_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_st == S_IDLE)
    `SMQ_ASSERT_IMP(a_stack_bound, i_clk, i_rst_n, 1'b1, r_sp <= (STK_BITS+1)'(STK_DEPTH))
endmodule

// ===== test/segment_max_point_query_tree_core_test.sv =====
// self-checking testbench for the segment max point query tree core
module segment_max_point_query_tree_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import smq_pkg::*;

    // run limit: clearing pass plus a worst-case insert walk per item, several times over
    localparam longint CYCLE_LIMIT = 131072 * 2 + 64'd40_000_000;
    localparam int     DRAIN_CYCLES = 200;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cfg_we = 1'b0;
    logic [15:0]         i_cfg_wdata = '0;
    logic                i_cmd = CMD_QUERY;
    logic [15:0]         i_query_pos = '0;
    logic [15:0]         i_seg_x0 = '0;
    logic [29:0]         i_seg_y0 = '0;
    logic [15:0]         i_seg_x1 = '0;
    logic [29:0]         i_seg_y1 = '0;
    logic                o_valid;
    logic [ID_BITS-1:0]  o_best_line;

    segment_max_point_query_tree_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_query_pos (i_query_pos),
        .i_seg_x0    (i_seg_x0),
        .i_seg_y0    (i_seg_y0),
        .i_seg_x1    (i_seg_x1),
        .i_seg_y1    (i_seg_y1),
        .o_valid     (o_valid),
        .o_best_line (o_best_line)
    );

    // one command transaction, with an optional hand-typed answer
    typedef struct {
        logic         cmd;
        logic [15:0]  pos;
        logic [15:0]  x0;
        logic [29:0]  y0;
        logic [15:0]  x1;
        logic [29:0]  y1;
        bit           typed;
        t_id          answer;
    } t_tree_cmd;

    // shadow copy of the tree and line stores
    int unsigned tree_upper;
    t_id         shadow_node [0:TREE_NODES-1];
    longint      shadow_slope [0:MAX_LINES];
    int unsigned shadow_sx [0:MAX_LINES];
    int unsigned shadow_sy [0:MAX_LINES];
    int unsigned shadow_next_id;

    t_id         pending_answers [$];
    t_tree_cmd   directed_rows [$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    int          burst_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[segment_max_point_query_tree_core] ERROR");
            $finish;
        end
    end

    // height of a line at p, 16 fraction bits, exact in 64 bits
    function automatic longint line_height(int unsigned id, int unsigned p);
        if (id == 0 || id > MAX_LINES) return 0;
        return (longint'(shadow_sy[id]) <<< FRAC_BITS) +
               shadow_slope[id] * (longint'(p) - longint'(shadow_sx[id]));
    endfunction

    // a strictly below b at p, equal heights: the larger id loses
    function automatic bit below(int unsigned a, int unsigned b, int unsigned p);
        longint ha, hb;
        ha = line_height(a, p);
        hb = line_height(b, p);
        if (ha != hb) return ha < hb;
        return a > b;
    endfunction

    // usual li chao descent from a fully covered node
    function automatic void sink_line(int unsigned node, int unsigned l, int unsigned r,
                                      int unsigned id);
        int unsigned cur, m;
        while (node < TREE_NODES) begin
            cur = 32'(shadow_node[node]);
            if (below(id, cur, l) && below(id, cur, r)) return;
            if (below(cur, id, l) && below(cur, id, r)) begin
                shadow_node[node] = t_id'(id);
                return;
            end
            if (l >= r) return;
            m = (l + r) >> 1;
            if (below(cur, id, m)) begin
                shadow_node[node] = t_id'(id);
                id = cur;
            end
            if (below(32'(shadow_node[node]), id, l)) begin
                node = node * 2;
                r = m;
            end else begin
                node = node * 2 + 1;
                l = m + 1;
            end
        end
    endfunction

    // split the segment over the covering nodes
    function automatic void cover_range(int unsigned node, int unsigned l, int unsigned r,
                                        int unsigned lo, int unsigned hi, int unsigned id);
        int unsigned m;
        if (node >= TREE_NODES || r < lo || hi < l || l > r) return;
        if (lo <= l && r <= hi) begin
            sink_line(node, l, r, id);
            return;
        end
        m = (l + r) >> 1;
        cover_range(node * 2, l, m, lo, hi, id);
        cover_range(node * 2 + 1, m + 1, r, lo, hi, id);
    endfunction

    // best line on the root-to-leaf path of x
    function automatic t_id highest_at(int unsigned x);
        int unsigned node, l, r, best, d, m;
        bit have;
        node = 1; l = 1; r = tree_upper; best = 0; have = 0;
        if (x < 1 || x > tree_upper) return '0;
        while (node < TREE_NODES) begin
            d = 32'(shadow_node[node]);
            if (!have || below(best, d, x)) begin
                best = d;
                have = 1;
            end
            if (l >= r) break;
            m = (l + r) >> 1;
            if (x <= m) begin
                node = node * 2;
                r = m;
            end else begin
                node = node * 2 + 1;
                l = m + 1;
            end
        end
        return t_id'(best);
    endfunction

    // apply an accepted transaction to the shadow tree, queue its answer
    function automatic void track_command(t_tree_cmd c);
        int unsigned x0, x1, y0, y1, t, id;
        longint num;
        if (c.cmd == CMD_QUERY) begin
            if (c.typed) pending_answers.push_back(c.answer);
            else pending_answers.push_back(highest_at(32'(c.pos)));
            return;
        end
        if (shadow_next_id >= MAX_LINES) return;    // ids used up, insert dropped
        shadow_next_id++;
        id = shadow_next_id;
        x0 = 32'(c.x0); y0 = 32'(c.y0); x1 = 32'(c.x1); y1 = 32'(c.y1);
        if (x1 < x0) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        shadow_sx[id] = x0;
        if (x0 == x1) begin
            // vertical: flat at the taller end
            shadow_slope[id] = 0;
            shadow_sy[id] = (y0 > y1) ? y0 : y1;
        end else begin
            num = (longint'(y1) - longint'(y0)) * (longint'(1) <<< FRAC_BITS);
            shadow_slope[id] = num / longint'(x1 - x0);
            shadow_sy[id] = y0;
        end
        if (tree_upper >= 1) cover_range(1, 1, tree_upper, x0, x1, id);
    endfunction

    // result checker, outputs sampled at the accepting edge
    always @(posedge i_clk) begin
        t_id want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $error("best_line: no transaction waiting, actual %0d", o_best_line);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_best_line !== want) begin
                    $error("best_line: expected %0d actual %0d", want, o_best_line);
                    fail_count++;
                end
            end
        end
    end

    // issue one transaction when the core is free, bursty sender
    task automatic send_command(t_tree_cmd c);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c.cmd;
        i_query_pos <= c.pos;
        i_seg_x0 <= c.x0;
        i_seg_y0 <= c.y0;
        i_seg_x1 <= c.x1;
        i_seg_y1 <= c.y1;
        track_command(c);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // hold off until all answers are in and the core is free
    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_answers.size() != 0 || busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_upper(int unsigned value);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[15:0];
        tree_upper = value & 16'hFFFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void add_row(logic cmd, int unsigned pos, int unsigned x0,
                                    int unsigned y0, int unsigned x1, int unsigned y1,
                                    bit typed, int unsigned answer);
        t_tree_cmd c;
        c.cmd = cmd; c.pos = 16'(pos); c.x0 = 16'(x0); c.y0 = 30'(y0);
        c.x1 = 16'(x1); c.y1 = 30'(y1);
        c.typed = typed; c.answer = t_id'(answer);
        directed_rows.push_back(c);
    endfunction

    // random coordinate, mostly inside the tree, sometimes anywhere in the field
    function automatic int unsigned pick_coord();
        int unsigned hi;
        hi = (tree_upper < 65533) ? tree_upper + 2 : 65535;
        if (hi < 2) hi = 2;
        if ($urandom_range(0, 9) == 0) return $urandom_range(1, 65535);
        return $urandom_range(1, hi);
    endfunction

    function automatic int unsigned pick_y();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 30'h3FFF_FFFF);
            1: return $urandom_range(1, 64);                // low, many ties
            2: return $urandom_range(30'h3FFF_FFC0, 30'h3FFF_FFFF);
            default: return $urandom_range(1, 1_000_000);
        endcase
    endfunction

    function automatic t_tree_cmd random_command();
        t_tree_cmd c;
        c.typed = 0;
        c.answer = '0;
        c.cmd = ($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_INSERT;
        c.pos = 16'(pick_coord());
        c.x0 = 16'(pick_coord());
        c.x1 = ($urandom_range(0, 15) == 0) ? c.x0 : 16'(pick_coord());
        c.y0 = 30'(pick_y());
        c.y1 = ($urandom_range(0, 7) == 0) ? c.y0 : 30'(pick_y());
        return c;
    endfunction

    initial begin
        int unsigned uppers [7];
        int unsigned phase_items;

        tree_upper = 40000;
        shadow_next_id = 0;
        foreach (shadow_node[i]) shadow_node[i] = '0;

        // directed table, x_upper at its reset value
        add_row(CMD_QUERY, 1, 0, 0, 0, 0, 1, 0);                  // empty tree
        add_row(CMD_QUERY, 40000, 0, 0, 0, 0, 1, 0);
        add_row(CMD_QUERY, 65535, 0, 0, 0, 0, 1, 0);              // outside the tree
        add_row(CMD_INSERT, 0, 1, 1, 65535, 30'h3FFF_FFFF, 0, 0); // extremes, clipped
        add_row(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0);
        add_row(CMD_QUERY, 40000, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INSERT, 0, 30000, 5, 100, 900000, 0, 0);      // reversed endpoints
        add_row(CMD_QUERY, 100, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INSERT, 0, 500, 7, 500, 30'h3FFF_FFFF, 0, 0); // vertical segment
        add_row(CMD_QUERY, 500, 0, 0, 0, 0, 0, 0);
        add_row(CMD_QUERY, 501, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INSERT, 0, 1, 1, 65535, 30'h3FFF_FFFF, 0, 0); // same line, tie on id
        add_row(CMD_QUERY, 20000, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INSERT, 0, 50000, 9, 60000, 9, 0, 0);         // wholly outside
        add_row(CMD_QUERY, 55000, 0, 0, 0, 0, 1, 0);
        add_row(CMD_INSERT, 0, 1, 1000, 40000, 1, 0, 0);          // falling line
        add_row(CMD_QUERY, 39999, 0, 0, 0, 0, 0, 0);
        add_row(CMD_INSERT, 0, 10, 65535, 20, 1, 0, 0);
        add_row(CMD_QUERY, 15, 0, 0, 0, 0, 0, 0);
        add_row(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0);

        // synchronous reset, then let the clearing pass finish
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);

        foreach (directed_rows[i]) send_command(directed_rows[i]);

        // settings: extremes, zero tree, small trees, reset value
        uppers[0] = 65535;
        uppers[1] = 1;
        uppers[2] = 0;
        uppers[3] = 16;
        uppers[4] = $urandom_range(2, 300);
        uppers[5] = 40000;
        uppers[6] = $urandom_range(1, 65535);
        foreach (uppers[p]) begin
            write_upper(uppers[p]);
            phase_items = (uppers[p] == 0) ? 60 : 310;
            for (int n = 0; n < phase_items; n++) begin
                send_command(random_command());
                // pause mid-phase once until every answer is back
                if (p == 0 && n == 150) wait_quiet();
            end
        end

        // drain and settle
        @(negedge i_clk);
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_answers.size() != 0) begin
            $error("best_line: %0d answers never arrived", pending_answers.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[segment_max_point_query_tree_core] OK");
        end else begin
            $display("[segment_max_point_query_tree_core] ERROR");
        end
        $finish;
    end
endmodule
